[sv/ioct_pkg.sv]
// Shared constants and types for the in-order completion tracker.
package ioct_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = 11;

  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DUP   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WREQ,
    S_WCHK
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    logic  wdata;
    addr_t raddr;
  } map_req_t;

endpackage

[sv/ioct_map.sv]
// Completion bitmap: one write port and one registered read port.
module ioct_map (
  input  logic              clk,
  input  ioct_pkg::map_req_t req,
  output logic              rdata
);

  logic mem [ioct_pkg::MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

[sv/ioct_ctrl.sv]
// Sequencer that clears the bitmap, marks items and advances the prefix pointer.
module ioct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ioct_pkg::count_t    item_index,
  input  ioct_pkg::count_t    count_eff,
  input  logic                map_rdata,
  output ioct_pkg::map_req_t  map_req,
  output logic                busy,
  output logic                done,
  output ioct_pkg::count_t    prefix_length,
  output ioct_pkg::status_t   status
);

  ioct_pkg::state_t  state, state_next;
  ioct_pkg::count_t  ptr, ptr_next;
  ioct_pkg::count_t  idx, idx_next;
  ioct_pkg::addr_t   clr_addr, clr_addr_next;
  ioct_pkg::status_t status_next;
  logic              done_next;
  ioct_pkg::count_t  in_dec;
  ioct_pkg::count_t  idx_dec;
  ioct_pkg::count_t  ptr_inc;

  assign in_dec  = item_index - ioct_pkg::CNT_W'(1);
  assign idx_dec = idx - ioct_pkg::CNT_W'(1);
  assign ptr_inc = ptr + ioct_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ioct_pkg::S_CLEAR;
      ptr      <= '0;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
    idx    <= idx_next;
    status <= status_next;
  end

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    idx_next      = idx;
    clr_addr_next = clr_addr;
    done_next     = 1'b0;
    status_next   = status;
    map_req       = '0;
    map_req.raddr = ptr[ioct_pkg::ADDR_W-1:0];
    case (state)
      ioct_pkg::S_CLEAR: begin
        map_req.we    = 1'b1;
        map_req.waddr = clr_addr;
        map_req.wdata = 1'b0;
        clr_addr_next = clr_addr + ioct_pkg::ADDR_W'(1);
        if (clr_addr == ioct_pkg::ADDR_W'(ioct_pkg::MAX_ITEMS - 1)) begin
          state_next = ioct_pkg::S_IDLE;
        end
      end
      ioct_pkg::S_IDLE: begin
        if (start) begin
          idx_next      = item_index;
          map_req.raddr = in_dec[ioct_pkg::ADDR_W-1:0];
          if (item_index == '0 || item_index > count_eff) begin
            done_next   = 1'b1;
            status_next = ioct_pkg::ST_RANGE;
          end else begin
            state_next = ioct_pkg::S_CHECK;
          end
        end
      end
      ioct_pkg::S_CHECK: begin
        if (map_rdata) begin
          done_next   = 1'b1;
          status_next = ioct_pkg::ST_DUP;
          state_next  = ioct_pkg::S_IDLE;
        end else begin
          map_req.we    = 1'b1;
          map_req.waddr = idx_dec[ioct_pkg::ADDR_W-1:0];
          map_req.wdata = 1'b1;
          status_next   = ioct_pkg::ST_OK;
          state_next    = ioct_pkg::S_WREQ;
        end
      end
      ioct_pkg::S_WREQ: begin
        if (ptr < count_eff) begin
          map_req.raddr = ptr[ioct_pkg::ADDR_W-1:0];
          state_next    = ioct_pkg::S_WCHK;
        end else begin
          done_next  = 1'b1;
          state_next = ioct_pkg::S_IDLE;
        end
      end
      ioct_pkg::S_WCHK: begin
        if (map_rdata) begin
          ptr_next = ptr_inc;
          if (ptr_inc < count_eff) begin
            map_req.raddr = ptr_inc[ioct_pkg::ADDR_W-1:0];
          end else begin
            done_next  = 1'b1;
            state_next = ioct_pkg::S_IDLE;
          end
        end else begin
          done_next  = 1'b1;
          state_next = ioct_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ioct_pkg::S_IDLE;
      end
    endcase
  end

  assign busy          = (state != ioct_pkg::S_IDLE);
  assign prefix_length = ptr;

endmodule

[sv/in_order_completion_tracker_top.sv]
// Top level of the in-order completion tracker.
// Each item names one completed entry, numbered 1 to the configured count.
// The tracker answers with the longest run 1..k of completed entries.
// Input: an item is taken at a clock edge where start is high and busy low.
// Output: done is high for one cycle with prefix_length and status valid.
// Status is accepted, index out of range, or duplicate ignored.
// An out-of-range item answers in the next cycle. A duplicate answers from
// the check state, using the bitmap read issued when the item was taken. An
// accepted item is written in the check state, then the prefix pointer walks
// from the write-request state through the pointer-walk state, one entry per
// read, so its time is set by how many entries the pointer passes.
// The bitmap lives in one memory with a single read and a single write port.
// After reset a clearing pass writes every bitmap entry with busy high;
// configuration writes are still taken during the pass.
// The count register resets to 1024 and is written with cfg_write high.
// The receiver cannot stall, so each result must be taken when done is high.
module in_order_completion_tracker_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [ioct_pkg::CNT_W-1:0] cfg_data,
  input  logic                      start,
  input  logic [ioct_pkg::CNT_W-1:0] item_index,
  output logic                      busy,
  output logic                      done,
  output logic [ioct_pkg::CNT_W-1:0] prefix_length,
  output logic [1:0]                status
);

  ioct_pkg::count_t   item_count;
  ioct_pkg::count_t   count_eff;
  ioct_pkg::map_req_t map_req;
  ioct_pkg::status_t  status_q;
  logic               map_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= ioct_pkg::CNT_W'(1024);
    end else if (cfg_write) begin
      item_count <= cfg_data;
    end
  end

  assign count_eff = (item_count > ioct_pkg::CNT_W'(ioct_pkg::MAX_ITEMS)) ?
                     ioct_pkg::CNT_W'(ioct_pkg::MAX_ITEMS) : item_count;

  ioct_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item_index    (item_index),
    .count_eff     (count_eff),
    .map_rdata     (map_rdata),
    .map_req       (map_req),
    .busy          (busy),
    .done          (done),
    .prefix_length (prefix_length),
    .status        (status_q)
  );

  ioct_map u_map (
    .clk   (clk),
    .req   (map_req),
    .rdata (map_rdata)
  );

  assign status = status_q;

endmodule

[sv/ioct_checker.sv]
// Port-level checks for the in-order completion tracker, bound to the top level.
module ioct_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic [ioct_pkg::CNT_W-1:0] item_index,
  input logic                       busy,
  input logic                       done,
  input logic [ioct_pkg::CNT_W-1:0] prefix_length,
  input logic [1:0]                 status
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("Tracker is not busy after reset.");

  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item_index == '0) |=> (done && status == ioct_pkg::ST_RANGE))
    else $error("Index zero did not give an out-of-range result.");

  a_work_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("Accepted item neither in progress nor answered.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != 2'd3 &&
              prefix_length <= ioct_pkg::CNT_W'(ioct_pkg::MAX_ITEMS)))
    else $error("Result carries an impossible status or length.");

endmodule

bind in_order_completion_tracker_top ioct_checker u_ioct_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .item_index    (item_index),
  .busy          (busy),
  .done          (done),
  .prefix_length (prefix_length),
  .status        (status)
);

[test/completion_tracker_checker.sv]
// Checker that predicts and compares every result of the in-order completion tracker.
`timescale 1ns / 100ps

module completion_tracker_checker
  import ioct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  count_t     cfg_data,
  input  logic       start,
  input  logic       busy,
  input  count_t     item_index,
  input  logic       done,
  input  count_t     prefix_length,
  input  logic [1:0] status,
  output int         outstanding,
  output int         failures
);

  typedef struct {
    count_t  length;
    status_t code;
  } ack_t;

  bit     completed [MAX_ITEMS];
  count_t frontier;
  count_t count_reg;
  ack_t   expected_acks [$];
  int     err_n = 0;

  initial begin
    outstanding = 0;
    failures    = 0;
  end

  function automatic ack_t mark_complete(count_t idx);
    ack_t a;
    int   n;
    n = (count_reg > MAX_ITEMS) ? MAX_ITEMS : int'(count_reg);
    if (idx == 0 || idx > n) begin
      a.code = ST_RANGE;
    end else if (completed[idx - 1]) begin
      a.code = ST_DUP;
    end else begin
      completed[idx - 1] = 1'b1;
      a.code = ST_OK;
      while (frontier < n && completed[frontier]) frontier++;
    end
    a.length = frontier;
    return a;
  endfunction

  always @(posedge clk) begin
    ack_t want;
    if (rst) begin
      completed = '{default: 1'b0};
      frontier  = '0;
      count_reg = count_t'(MAX_ITEMS);
      expected_acks.delete();
    end else begin
      if (cfg_write) count_reg = cfg_data;
      if (done) begin
        if (expected_acks.size() == 0) begin
          $error("result with no item waiting: prefix_length %0d, status %0d",
                 prefix_length, status);
          err_n++;
        end else begin
          want = expected_acks.pop_front();
          if (prefix_length !== want.length) begin
            $error("prefix_length: expected %0d, actual %0d", want.length, prefix_length);
            err_n++;
          end
          if (status !== want.code) begin
            $error("status: expected %0d, actual %0d", want.code, status);
            err_n++;
          end
        end
      end
      if (start && !busy) expected_acks.push_back(mark_complete(item_index));
    end
    outstanding <= expected_acks.size();
    failures    <= err_n;
  end

endmodule

[test/in_order_completion_tracker_top_tb.sv]
// Testbench top: drives the completion tracker with items and gives the verdict.
`timescale 1ns / 100ps

module in_order_completion_tracker_top_tb;
  import ioct_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  count_t     cfg_data;
  logic       start;
  count_t     item_index;
  logic       busy;
  logic       done;
  count_t     prefix_length;
  logic [1:0] status;

  int outstanding;
  int failures;
  int cycles = 0;
  int sent = 0;
  int gap_pct;
  bit used_map [1:MAX_ITEMS];
  int used_q [$];

  in_order_completion_tracker_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .start         (start),
    .item_index    (item_index),
    .busy          (busy),
    .done          (done),
    .prefix_length (prefix_length),
    .status        (status)
  );

  completion_tracker_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .item_index    (item_index),
    .done          (done),
    .prefix_length (prefix_length),
    .status        (status),
    .outstanding   (outstanding),
    .failures      (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input int idx, input int lim);
    gap_pct = (sent < 350) ? 24 : (sent < 700) ? 57 : 0;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    item_index <= idx[CNT_W-1:0];
    do @(posedge clk); while (busy);
    sent++;
    if (idx >= 1 && idx <= lim && !used_map[idx]) begin
      used_map[idx] = 1'b1;
      used_q.push_back(idx);
    end
  endtask

  task automatic set_count(input int value);
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    cfg_write <= 1'b1;
    cfg_data  <= value[CNT_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int pick_noise(input int lim);
    if (used_q.size() > 0 && $urandom_range(1) == 1)
      return used_q[$urandom_range(used_q.size() - 1)];
    if (lim >= 2047 || $urandom_range(3) == 0)
      return 0;
    return $urandom_range(2047, lim + 1);
  endfunction

  task automatic run_phase(input int cnt, input bit noise_only, input int spread);
    int lim;
    int pool [$];
    int i;
    int j;
    int tmp;
    lim = (cnt > MAX_ITEMS) ? MAX_ITEMS : cnt;
    set_count(cnt);
    if (noise_only) begin
      repeat (12) send_item(pick_noise(lim), lim);
    end else begin
      for (i = 1; i <= lim; i++) if (!used_map[i]) pool.push_back(i);
      for (i = pool.size() - 1; i > 0; i--) begin
        j = $urandom_range(i, (i > spread) ? i - spread : 0);
        tmp = pool[i];
        pool[i] = pool[j];
        pool[j] = tmp;
      end
      while (pool.size() > 0) begin
        if ($urandom_range(19) == 0) send_item(pick_noise(lim), lim);
        else send_item(pool.pop_front(), lim);
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_data   = '0;
    start      = 1'b0;
    item_index = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed items: empty stream, small stream, shrink below the prefix, oversized count.
    set_count(0);
    send_item(0, 0);
    send_item(1, 0);
    send_item(1024, 0);
    set_count(5);
    send_item(0, 5);
    send_item(6, 5);
    send_item(2047, 5);
    send_item(3, 5);
    send_item(1, 5);
    send_item(1, 5);
    send_item(2, 5);
    send_item(5, 5);
    send_item(4, 5);
    set_count(3);
    send_item(4, 3);
    send_item(3, 3);
    set_count(2047);
    send_item(1024, MAX_ITEMS);
    send_item(1025, MAX_ITEMS);
    send_item(6, MAX_ITEMS);

    run_phase(100, 1'b0, 8);
    run_phase(40, 1'b1, 0);
    run_phase(1, 1'b1, 0);
    run_phase(400, 1'b0, 1000);
    run_phase(750, 1'b0, 8);
    run_phase(2047, 1'b0, 32);
    run_phase(1024, 1'b1, 0);
    run_phase(0, 1'b1, 0);

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[in_order_completion_tracker_top.f]
sv/ioct_pkg.sv
sv/ioct_map.sv
sv/ioct_ctrl.sv
sv/in_order_completion_tracker_top.sv
sv/ioct_checker.sv
test/completion_tracker_checker.sv
test/in_order_completion_tracker_top_tb.sv
